@@ sv/anl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anl_pkg
// Shared types, codes and helpers of the Annex-B to length-prefixed NAL
// converter.
// ----------------------------------------------------------------------------
package anl_pkg;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_NAL_END = 2'd1;
    localparam logic [1:0] KIND_UNIT_END = 2'd2;

    // configuration port
    localparam int unsigned ADDR_W = 3;
    localparam logic [0:0] REG_CODEC_MODE = 1'b0;

    // codec selection
    localparam logic CODEC_H264 = 1'b0;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
    localparam logic [33:0] LEN_PREFIX_BYTES = 34'd4;
    localparam logic [7:0] TYPE_MASK_AVC = 8'h1f;
    localparam logic [7:0] TYPE_MASK_HEVC = 8'h3f;

    // Results caused by one input item, in output order:
    // nz payload zeros, then the item's own byte, then the NAL end, then
    // the access unit end.
    typedef struct packed {
        logic [2:0]  nz;
        logic        has_byte;
        logic [7:0]  data;
        logic        has_nal;
        logic [31:0] nal_len;
        logic [5:0]  nal_type;
        logic        has_unit;
        logic [31:0] unit_bytes;
        logic        empty;
    } desc_t;

    // NAL type field from the first payload byte
    function automatic logic [5:0] nal_type_of(input logic mode, input logic [7:0] b);
        logic [7:0] t;
        begin
            if (mode == CODEC_H264) begin
                t = b & TYPE_MASK_AVC;
            end else begin
                t = (b >> 1) & TYPE_MASK_HEVC;
            end
            nal_type_of = t[5:0];
        end
    endfunction

endpackage

@@ sv/annexb_to_length_prefixed_nal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_to_length_prefixed_nal
// Strips Annex-B start codes from a byte stream, passes NAL payload bytes
// and reports NAL lengths/types and the converted access unit size.
// ----------------------------------------------------------------------------
// Each item's results are registered in the descriptor queue before they are offered.
// Throughput: one byte per cycle while m_ready is high and each byte yields at
//   most one result; a byte yielding n results (up to 6) holds the single
//   result port for n handshakes, buffered by a two-entry descriptor queue.
// Reset: synchronous, active low; clears stream state, queue and codec_mode.
module annexb_to_length_prefixed_nal (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [anl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // input bytes
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_data_byte,
    input  logic                       s_unit_end,
    // results
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_kind,
    output logic [7:0]                 m_payload_byte,
    output logic [31:0]                m_nal_length,
    output logic [5:0]                 m_nal_type,
    output logic [31:0]                m_unit_bytes,
    output logic                       m_empty_unit,
    output logic                       m_last
);

    logic           codec_mode_reg;
    logic           cfg_sel;
    logic           q_ready;
    logic           push_valid;
    anl_pkg::desc_t push_desc;

    // register file
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == anl_pkg::REG_CODEC_MODE) && (paddr[1:0] == 2'b00);
    assign prdata  = cfg_sel ? {31'd0, codec_mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == anl_pkg::REG_CODEC_MODE) begin
            codec_mode_reg <= pwdata[0];
        end
    end

    assign s_ready = q_ready;

    anl_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .codec_mode  (codec_mode_reg),
        .s_valid     (s_valid),
        .s_data_byte (s_data_byte),
        .s_unit_end  (s_unit_end),
        .q_ready     (q_ready),
        .push_valid  (push_valid),
        .push_desc   (push_desc)
    );

    anl_outq u_outq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .push_valid     (push_valid),
        .push_desc      (push_desc),
        .q_ready        (q_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_payload_byte (m_payload_byte),
        .m_nal_length   (m_nal_length),
        .m_nal_type     (m_nal_type),
        .m_unit_bytes   (m_unit_bytes),
        .m_empty_unit   (m_empty_unit),
        .m_last         (m_last)
    );

`ifndef SYNTHESIS
    // last flag marks exactly the access unit result
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_kind == anl_pkg::KIND_UNIT_END)))
        else $error("last flag does not match unit end result");

    // empty NAL units are never reported
    a_nal_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == anl_pkg::KIND_NAL_END) |-> (m_nal_length != 32'd0))
        else $error("zero length NAL reported");

    // empty flag agrees with the converted size
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == anl_pkg::KIND_UNIT_END)
            |-> (m_empty_unit == (m_unit_bytes == 32'd0)))
        else $error("empty unit flag disagrees with size");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");
`endif

endmodule

@@ sv/anl_parse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anl_parse
// Start code detector and NAL bookkeeping: one input byte per cycle, while the
// queue has room, is turned into a result descriptor while the stream state is updated.
// ----------------------------------------------------------------------------
module anl_parse (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            codec_mode,
    input  logic            s_valid,
    input  logic [7:0]      s_data_byte,
    input  logic            s_unit_end,
    input  logic            q_ready,
    output logic            push_valid,
    output anl_pkg::desc_t  push_desc
);

    logic [1:0]  held_reg, held_next;
    logic        inside_reg, inside_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [5:0]  type_reg, type_next;
    logic [31:0] tot_reg, tot_next;

    logic        accept;
    logic        is_zero;
    logic        is_sc;
    logic [2:0]  zeros_a;
    logic [1:0]  held_a;
    logic [2:0]  nz;
    logic        byte_flag;
    logic [2:0]  passed;
    logic [32:0] cnt_sum;
    logic [31:0] cnt_new;
    logic [5:0]  type_new;
    logic [33:0] tot_sum;
    logic [31:0] tot_sat;
    logic        has_nal;
    logic [31:0] nal_len;
    logic [5:0]  nal_type;
    logic [31:0] tot_after;

    assign accept = s_valid && q_ready;

    // byte classification and zero run handling
    always_comb begin
        is_zero = (s_data_byte == 8'h00);
        is_sc   = (s_data_byte == 8'h01) && (held_reg >= 2'd2);
        if (is_zero) begin
            zeros_a = (held_reg == 2'd3) ? 3'd1 : 3'd0;
            held_a  = (held_reg == 2'd3) ? 2'd3 : held_reg + 2'd1;
        end else begin
            zeros_a = is_sc ? 3'd0 : {1'b0, held_reg};
            held_a  = 2'd0;
        end
        nz        = 3'd0;
        byte_flag = 1'b0;
        if (inside_reg && !is_sc) begin
            // trailing held zeros go to the last NAL at the unit end
            nz        = zeros_a + (s_unit_end ? {1'b0, held_a} : 3'd0);
            byte_flag = !is_zero;
        end
        passed = nz + {2'b00, byte_flag};
    end

    // counters, saturating; unit total adds in parallel with the count
    always_comb begin
        cnt_sum = {1'b0, cnt_reg} + {30'd0, passed};
        cnt_new = cnt_sum[32] ? anl_pkg::SAT32 : cnt_sum[31:0];
        if (cnt_reg == 32'd0 && passed != 3'd0) begin
            type_new = (nz != 3'd0) ? 6'd0 : anl_pkg::nal_type_of(codec_mode, s_data_byte);
        end else begin
            type_new = type_reg;
        end
        tot_sum = {2'b00, tot_reg} + anl_pkg::LEN_PREFIX_BYTES + {2'b00, cnt_reg}
                + {31'd0, passed};
        tot_sat = (tot_sum[33:32] != 2'b00) ? anl_pkg::SAT32 : tot_sum[31:0];
        if (is_sc) begin
            has_nal  = inside_reg && (cnt_reg != 32'd0);
            nal_len  = cnt_reg;
            nal_type = type_reg;
        end else begin
            has_nal  = s_unit_end && inside_reg && (cnt_new != 32'd0);
            nal_len  = cnt_new;
            nal_type = type_new;
        end
        tot_after = has_nal ? tot_sat : tot_reg;
    end

    // descriptor for the output queue
    always_comb begin
        push_desc.nz         = nz;
        push_desc.has_byte   = byte_flag;
        push_desc.data       = s_data_byte;
        push_desc.has_nal    = has_nal;
        push_desc.nal_len    = nal_len;
        push_desc.nal_type   = nal_type;
        push_desc.has_unit   = s_unit_end;
        push_desc.unit_bytes = tot_after;
        push_desc.empty      = (tot_after == 32'd0);
        push_valid = accept && (nz != 3'd0 || byte_flag || has_nal || s_unit_end);
    end

    // next stream state
    always_comb begin
        held_next   = held_reg;
        inside_next = inside_reg;
        cnt_next    = cnt_reg;
        type_next   = type_reg;
        tot_next    = tot_reg;
        if (accept) begin
            if (s_unit_end) begin
                held_next   = 2'd0;
                inside_next = 1'b0;
                cnt_next    = 32'd0;
                type_next   = 6'd0;
                tot_next    = 32'd0;
            end else if (is_sc) begin
                held_next   = 2'd0;
                inside_next = 1'b1;
                cnt_next    = 32'd0;
                type_next   = 6'd0;
                tot_next    = tot_after;
            end else begin
                held_next = held_a;
                cnt_next  = cnt_new;
                type_next = type_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg   <= 2'd0;
            inside_reg <= 1'b0;
            cnt_reg    <= 32'd0;
            type_reg   <= 6'd0;
            tot_reg    <= 32'd0;
        end else begin
            held_reg   <= held_next;
            inside_reg <= inside_next;
            cnt_reg    <= cnt_next;
            type_reg   <= type_next;
            tot_reg    <= tot_next;
        end
    end

endmodule

@@ sv/anl_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anl_outq
// Two-entry descriptor queue; the head descriptor is unrolled into single
// results, one per output handshake.
// ----------------------------------------------------------------------------
module anl_outq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    input  anl_pkg::desc_t  push_desc,
    output logic            q_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      m_kind,
    output logic [7:0]      m_payload_byte,
    output logic [31:0]     m_nal_length,
    output logic [5:0]      m_nal_type,
    output logic [31:0]     m_unit_bytes,
    output logic            m_empty_unit,
    output logic            m_last
);

    anl_pkg::desc_t q_reg [2];
    logic [1:0] count_reg, count_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;

    anl_pkg::desc_t head;
    anl_pkg::desc_t head_upd;
    logic sel_zero, sel_byte, sel_nal;
    logic out_fire, pop;

    assign head    = q_reg[rd_reg];
    assign q_ready = (count_reg != 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign out_fire = m_valid && m_ready;

    // pick the next result of the head item
    always_comb begin
        sel_zero = (head.nz != 3'd0);
        sel_byte = !sel_zero && head.has_byte;
        sel_nal  = !sel_zero && !head.has_byte && head.has_nal;
        head_upd = head;
        if (sel_zero) begin
            head_upd.nz = head.nz - 3'd1;
        end else if (sel_byte) begin
            head_upd.has_byte = 1'b0;
        end else if (sel_nal) begin
            head_upd.has_nal = 1'b0;
        end else begin
            head_upd.has_unit = 1'b0;
        end
        pop = out_fire && (head_upd.nz == 3'd0) && !head_upd.has_byte
            && !head_upd.has_nal && !head_upd.has_unit;
    end

    // result fields
    always_comb begin
        m_kind         = anl_pkg::KIND_UNIT_END;
        m_payload_byte = 8'd0;
        m_nal_length   = 32'd0;
        m_nal_type     = 6'd0;
        m_unit_bytes   = 32'd0;
        m_empty_unit   = 1'b0;
        m_last         = 1'b0;
        if (sel_zero) begin
            m_kind = anl_pkg::KIND_PAYLOAD;
        end else if (sel_byte) begin
            m_kind         = anl_pkg::KIND_PAYLOAD;
            m_payload_byte = head.data;
        end else if (sel_nal) begin
            m_kind       = anl_pkg::KIND_NAL_END;
            m_nal_length = head.nal_len;
            m_nal_type   = head.nal_type;
        end else begin
            m_unit_bytes = head.unit_bytes;
            m_empty_unit = head.empty;
            m_last       = 1'b1;
        end
    end

    // queue pointers
    always_comb begin
        count_next = count_reg + {1'b0, push_valid} - {1'b0, pop};
        rd_next    = pop ? !rd_reg : rd_reg;
        wr_next    = push_valid ? !wr_reg : wr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end else begin
            count_reg <= count_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
        end
    end

    // entries: head shrinks in place, push writes the slot at the write pointer
    always_ff @(posedge aclk) begin
        if (out_fire && !pop) begin
            q_reg[rd_reg] <= head_upd;
        end
        if (push_valid) begin
            q_reg[wr_reg] <= push_desc;
        end
    end

endmodule
